/* sv/suwi_pkg.sv */
package suwi_pkg;
  localparam int unsigned MaxIdsDefault = 64;
  localparam int unsigned IdWidthDefault = 64;
  localparam int unsigned PosW = 6;
  localparam int unsigned CntW = 7;
  localparam int unsigned ValW = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_RANK,
    ST_EMIT
  } back_state_t;
endpackage

/* sv/suwi_ram.sv */
module suwi_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];

  // write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

/* sv/suwi_front.sv */
module suwi_front #(
  parameter int unsigned IdWidth = suwi_pkg::IdWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [suwi_pkg::ValW-1:0] in_id_value,
  input  logic                     in_batch_end,
  output logic                     q_valid,
  input  logic                     q_take,
  output logic [suwi_pkg::ValW-1:0] q_id,
  output logic                     q_end
);
  // two-entry queue of fitted ids
  logic [suwi_pkg::ValW-1:0] id_r [2];
  logic [1:0]                end_r;
  logic                      wp_r, rp_r;
  logic [1:0]                cnt_r;
  logic [suwi_pkg::ValW-1:0] fit;
  logic                      push_ok, take_ok;

  // sign-extend the id from its top used bit
  assign fit = suwi_pkg::ValW'($signed(in_id_value[IdWidth-1:0]));
  assign in_full = cnt_r == 2'd2;
  assign push_ok = in_push && !in_full;
  assign q_valid = cnt_r != 2'd0;
  assign take_ok = q_take && q_valid;
  assign q_id = id_r[rp_r];
  assign q_end = end_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      id_r[wp_r] <= fit;
      end_r[wp_r] <= in_batch_end;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (take_ok) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, take_ok};
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !q_take) |=> in_full) else $error("full dropped without take");
  a_empty_take: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |=> (cnt_r <= 2'd1)) else $error("queue grew too fast");
`endif
endmodule

/* sv/suwi_back.sv */
module suwi_back #(
  parameter int unsigned MaxIds = suwi_pkg::MaxIdsDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_take,
  input  logic [suwi_pkg::ValW-1:0] q_id,
  input  logic                      q_end,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [suwi_pkg::PosW-1:0] out_position,
  output logic [suwi_pkg::PosW-1:0] out_inverse_index,
  output logic [suwi_pkg::ValW-1:0] out_unique_value,
  output logic                      out_unique_valid,
  output logic [suwi_pkg::CntW-1:0] out_unique_count,
  output logic                      out_overflow,
  output logic                      out_run_end
);
  localparam int unsigned AW = (MaxIds > 1) ? $clog2(MaxIds) : 1;
  localparam int unsigned CW = $clog2(MaxIds + 1);
  localparam int unsigned VW = suwi_pkg::ValW;

  // sorted (value, position) cells; insertion shifts up, rank walk shifts down
  logic [VW-1:0] sv_r [MaxIds];
  logic [AW-1:0] sp_r [MaxIds];
  logic [MaxIds-1:0] lt;
  logic [MaxIds-1:0] sh;
  logic [CW-1:0] n_r;
  logic          ovf_r;
  suwi_pkg::back_state_t st_r, st_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] uc_r;
  logic [VW-1:0] last_r;
  logic          ld;
  logic          stored;

  // rank and unique memories
  logic          rk_we, uq_we;
  logic [AW-1:0] rk_wa, uq_wa, rd_a;
  logic [suwi_pkg::PosW-1:0] rk_wd, rk_rd;
  logic [VW-1:0] uq_rd;
  logic [suwi_pkg::PosW-1:0] rank_cur;

  assign ld = (st_r == suwi_pkg::ST_LOAD) && q_valid;
  assign q_take = st_r == suwi_pkg::ST_LOAD;
  assign stored = ld && (n_r < CW'(MaxIds));

  // compare new id against every occupied slot (signed)
  always_comb begin
    for (int k = 0; k < MaxIds; k++) begin
      lt[k] = (CW'(k) < n_r) && ($signed(q_id) < $signed(sv_r[k]));
    end
  end

  // a slot takes its lower neighbour when that neighbour moves up
  always_comb begin
    sh[0] = 1'b0;
    for (int k = 1; k < MaxIds; k++) begin
      sh[k] = lt[k-1];
    end
  end

  // insert on load; drain from slot 0 during the rank walk
  always_ff @(posedge clk) begin
    if (stored) begin
      for (int k = 0; k < MaxIds; k++) begin
        if (sh[k]) begin
          sv_r[k] <= sv_r[(k == 0) ? 0 : k-1];
          sp_r[k] <= sp_r[(k == 0) ? 0 : k-1];
        end else if (lt[k] || CW'(k) == n_r) begin
          sv_r[k] <= q_id;
          sp_r[k] <= AW'(n_r);
        end
      end
    end else if (rk_we) begin
      for (int k = 0; k + 1 < MaxIds; k++) begin
        sv_r[k] <= sv_r[k+1];
        sp_r[k] <= sp_r[k+1];
      end
    end
  end

  // rank walk over sorted slots, always at the head cell
  assign rank_cur = (i_r == '0 || sv_r[0] != last_r) ?
                    suwi_pkg::PosW'(uc_r) : suwi_pkg::PosW'(uc_r - 1'b1);
  assign rk_we = st_r == suwi_pkg::ST_RANK;
  assign rk_wa = sp_r[0];
  assign rk_wd = rank_cur;
  assign uq_we = rk_we && (i_r == '0 || sv_r[0] != last_r);
  assign uq_wa = AW'(uc_r);
  assign rd_a  = AW'(i_r);

  suwi_ram #(.Width(suwi_pkg::PosW), .Depth(MaxIds)) u_rank (
    .clk, .we(rk_we), .waddr(rk_wa), .wdata(rk_wd), .raddr(rd_a), .rdata(rk_rd));
  suwi_ram #(.Width(VW), .Depth(MaxIds)) u_uniq (
    .clk, .we(uq_we), .waddr(uq_wa), .wdata(sv_r[0]), .raddr(rd_a),
    .rdata(uq_rd));

  // output register
  logic          ov_r;
  logic [AW-1:0] op_r;
  logic          emit_go;

  always_comb begin
    st_nxt = st_r;
    i_nxt = i_r;
    emit_go = 1'b0;
    unique case (st_r)
      suwi_pkg::ST_LOAD: begin
        if (ld && q_end) begin
          st_nxt = suwi_pkg::ST_RANK;
          i_nxt = '0;
        end
      end
      suwi_pkg::ST_RANK: begin
        if (i_r + 1'b1 == n_r) begin
          st_nxt = suwi_pkg::ST_SORT_RD;
          i_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      suwi_pkg::ST_SORT_RD: begin
        // read issued for i_r; data next cycle
        if (!ov_r) st_nxt = suwi_pkg::ST_EMIT;
      end
      suwi_pkg::ST_EMIT: begin
        emit_go = 1'b1;
        if (i_r + 1'b1 == n_r) begin
          st_nxt = suwi_pkg::ST_SORT_CMP;
        end else begin
          i_nxt = i_r + 1'b1;
          st_nxt = suwi_pkg::ST_SORT_RD;
        end
      end
      suwi_pkg::ST_SORT_CMP: begin
        // wait for the last beat to leave
        if (!ov_r) begin
          st_nxt = suwi_pkg::ST_LOAD;
          i_nxt = '0;
        end
      end
      default: st_nxt = suwi_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      last_r <= sv_r[0];
    end
    if (emit_go) begin
      op_r <= AW'(i_r);
      out_inverse_index <= rk_rd;
      out_unique_valid <= i_r < uc_r;
      out_unique_value <= (i_r < uc_r) ? uq_rd : '0;
      out_unique_count <= suwi_pkg::CntW'(uc_r);
      out_overflow <= ovf_r;
      out_run_end <= i_r + 1'b1 == n_r;
    end
    if (!rst_n) begin
      st_r <= suwi_pkg::ST_LOAD;
      i_r <= '0;
      n_r <= '0;
      ovf_r <= 1'b0;
      uc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      i_r <= i_nxt;
      if (stored) n_r <= n_r + 1'b1;
      if (ld && !stored) ovf_r <= 1'b1;
      if (uq_we) uc_r <= uc_r + 1'b1;
      if (emit_go) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
      if (st_r == suwi_pkg::ST_SORT_CMP && !ov_r) begin
        n_r <= '0;
        ovf_r <= 1'b0;
        uc_r <= '0;
      end
    end
  end

  assign out_empty = !ov_r;
  assign out_position = suwi_pkg::PosW'(op_r);

`ifndef SYNTH
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MaxIds)) else $error("load count past capacity");
  a_uc_le_n: assert property (@(posedge clk) disable iff (!rst_n)
    uc_r <= n_r) else $error("unique count above load count");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> !ov_r) else $error("result overwritten");
`endif
endmodule

/* sv/sorted_unique_with_inverse.sv */
// Flow: the batch-closing beat enters the front queue and is taken by the
// back end, which ranks the sorted cells, then reads and registers results.
// Throughput: ids load at 1 per cycle while the back end is loading; each
// result waits for the previous beat to be popped, and the back end takes no
// ids from the closing beat until the last pop, while the front queue fills.
// Reset (rst_n low, synchronous) empties the queue and starts a new batch.
module sorted_unique_with_inverse #(
  parameter int unsigned MaxIds  = suwi_pkg::MaxIdsDefault,
  parameter int unsigned IdWidth = suwi_pkg::IdWidthDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [suwi_pkg::ValW-1:0] in_id_value,
  input  logic                      in_batch_end,
  output logic                      empty,
  input  logic                      pop,
  output logic [suwi_pkg::PosW-1:0] out_position,
  output logic [suwi_pkg::PosW-1:0] out_inverse_index,
  output logic [suwi_pkg::ValW-1:0] out_unique_value,
  output logic                      out_unique_valid,
  output logic [suwi_pkg::CntW-1:0] out_unique_count,
  output logic                      out_overflow,
  output logic                      out_run_end
);
  logic                      q_valid, q_take, q_end;
  logic [suwi_pkg::ValW-1:0] q_id;

  suwi_front #(.IdWidth(IdWidth)) u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_id_value,
    .in_batch_end, .q_valid, .q_take, .q_id, .q_end);

  suwi_back #(.MaxIds(MaxIds)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_id, .q_end,
    .out_empty(empty), .out_pop(pop), .out_position, .out_inverse_index,
    .out_unique_value, .out_unique_valid, .out_unique_count,
    .out_overflow, .out_run_end);
endmodule
